// File: design/rfd_pkg.sv
package rfd_pkg;

   localparam int NUM_ENDPOINTS     = 16;
   localparam int REGS_PER_ENDPOINT = 3;
   localparam int BUFFER_WORDS      = 32;
   localparam int PAGE_BYTES        = 4096;

   localparam int N_UNIT = 4;
   localparam int N_CMD  = 3;
   localparam int N_PRIV = 6;
   localparam int N_EPW  = NUM_ENDPOINTS * REGS_PER_ENDPOINT;

   // word indexes in the address map, and SPACE_END as the byte address of its end
   localparam int EP_WORD    = N_UNIT + N_CMD;
   localparam int BUF_WORD   = EP_WORD + N_EPW;
   localparam int PRIV_WORD  = (PAGE_BYTES * 2) / 8;
   localparam int SPACE_END  = PAGE_BYTES * 2 + 8 * N_PRIV;

   // flat storage layout: unit, command, endpoint, buffer, privileged
   localparam int PRIV_FLAT  = BUF_WORD + BUFFER_WORDS;
   localparam int N_WORDS    = PRIV_FLAT + N_PRIV;
   localparam int IDX_W      = $clog2(N_WORDS);

   localparam int UNIT_FEATURES  = 0;
   localparam int UNIT_CUR_TIME  = 1;
   localparam int UNIT_IRQ_CLEAR = 2;
   localparam int UNIT_PRINT     = 3;

   localparam int CMD_COMMAND = 0;

   localparam int PRIV_CORE_CALL = 0;
   localparam int PRIV_PRIV_OP   = 1;
   localparam int PRIV_EXT_CMD   = 3;
   localparam int PRIV_CUR_VPE   = 4;

   localparam logic [63:0] FEAT_PRIV_BIT = 64'h1;
   localparam logic [63:0] INVALID_VPE   = 64'hFFFF;

   localparam logic [1:0] RDSEL_ZERO = 2'd0;
   localparam logic [1:0] RDSEL_TIME = 2'd1;
   localparam logic [1:0] RDSEL_MEM  = 2'd2;

   typedef struct packed {
      logic irq_clear;
      logic print;
      logic core_call;
      logic priv_op;
      logic ext_cmd;
      logic command;
      logic ignored;
      logic denied;
   } rsp_flags_type;

   function automatic logic [63:0] reset_word(input logic [IDX_W-1:0] idx);
      logic [63:0] val;
      val = 64'h0;
      if (idx == IDX_W'(UNIT_FEATURES)) begin
         val = FEAT_PRIV_BIT;
      end else if (idx == IDX_W'(PRIV_FLAT + PRIV_CUR_VPE)) begin
         val = INVALID_VPE;
      end
      return val;
   endfunction

endpackage

// File: design/rfd_ram.sv
module rfd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/tcu_register_file_decode.sv
// Register file decoder for a message-passing unit.
//
// Request channel (req_*): one 64-bit register access per item, a read or a
// write, from the local core or the network, with byte address, write data
// and the current time. Response channel (rsp_*): one item per request with
// read data and the side-effect, ignored and denied flags.
//
// All register words live in one single-port-write, registered-read RAM.
// An item is decoded and written or read in the cycle it is accepted and is
// held in the decode stage; the RAM output is formatted when that stage moves
// on and lands in the response register, which drives rsp_valid. One item is
// accepted per cycle while the response side keeps up; the RAM read port
// bounds it at that figure.
//
// Reset clears a per-word valid vector, so every word reads its reset value
// (features with the privileged bit, current VPE invalid) until written;
// no clearing pass is needed. When rsp_stall is high the response holds,
// one more item may sit in the decode stage, and then req_stall rises.
module tcu_register_file_decode import rfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic        req_from_cpu,
   input  logic [13:0] req_byte_addr,
   input  logic [63:0] req_wdata,
   input  logic [63:0] req_time_now,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_rdata,
   output logic        rsp_irq_clear_wr,
   output logic        rsp_print_wr,
   output logic        rsp_core_call_wr,
   output logic        rsp_priv_op_wr,
   output logic        rsp_ext_cmd_wr,
   output logic        rsp_command_wr,
   output logic        rsp_ignored,
   output logic        rsp_denied
);

   // decode stage
   logic                s1_valid_ff, s1_valid_in;
   rsp_flags_type       s1_flags_ff;
   logic [1:0]          s1_rdsel_ff;
   logic [63:0]         s1_time_ff;
   logic                s1_hit_ff;
   logic [IDX_W-1:0]    s1_idx_ff;

   // response stage
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_flags_type       rsp_flags_ff;
   logic [63:0]         rsp_rdata_ff, rsp_rdata_in;

   logic [N_WORDS-1:0]  valid_ff, valid_in;
   logic                priv_ff, priv_in;

   logic                accept, s1_move;
   logic [31:0]         addr_ext, word, rel;
   rsp_flags_type       flags;
   logic [1:0]          rdsel;
   logic [IDX_W-1:0]    idx;
   logic                mem_wr, mem_rd;
   logic [63:0]         ram_q;

   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;

   assign addr_ext = 32'(req_byte_addr);
   assign word     = addr_ext >> 3;

   always_comb begin
      flags   = '0;
      rdsel   = RDSEL_ZERO;
      idx     = IDX_W'(word);
      mem_wr  = 1'b0;
      mem_rd  = 1'b0;
      priv_in = priv_ff;
      rel     = 32'd0;
      if (addr_ext[2:0] != 3'd0 || addr_ext + 32'd8 > 32'(SPACE_END)) begin
         flags.ignored = 1'b1;
      end else if (word < 32'(N_UNIT)) begin
         if (!req_cmd) begin
            if (word == 32'(UNIT_CUR_TIME)) begin
               rdsel = RDSEL_TIME;
            end else begin
               rdsel  = RDSEL_MEM;
               mem_rd = 1'b1;
            end
         end else if (req_from_cpu) begin
            if (word == 32'(UNIT_IRQ_CLEAR)) begin
               flags.irq_clear = 1'b1;
               mem_wr          = 1'b1;
            end else if (word == 32'(UNIT_PRINT)) begin
               flags.print = 1'b1;
               mem_wr      = 1'b1;
            end
         end else begin
            mem_wr = 1'b1;
            if (word == 32'(UNIT_FEATURES)) begin
               priv_in = req_wdata[0];
            end
         end
      end else if (word >= 32'(PRIV_WORD)) begin
         rel = word - 32'(PRIV_WORD);
         idx = IDX_W'(rel + 32'(PRIV_FLAT));
         if (rel < 32'(N_PRIV)) begin
            if (!req_cmd) begin
               rdsel  = RDSEL_MEM;
               mem_rd = 1'b1;
            end else begin
               flags.core_call = (rel == 32'(PRIV_CORE_CALL));
               flags.priv_op   = (rel == 32'(PRIV_PRIV_OP));
               flags.ext_cmd   = (rel == 32'(PRIV_EXT_CMD)) && !req_from_cpu;
               mem_wr          = (rel != 32'(PRIV_EXT_CMD)) || !req_from_cpu;
            end
         end
      end else if (word < 32'(EP_WORD)) begin
         if (!req_cmd) begin
            rdsel  = RDSEL_MEM;
            mem_rd = 1'b1;
         end else if (req_from_cpu) begin
            flags.command = (word == 32'(N_UNIT + CMD_COMMAND));
            mem_wr        = 1'b1;
         end
      end else if (word < 32'(BUF_WORD)) begin
         if (!req_cmd) begin
            rdsel  = RDSEL_MEM;
            mem_rd = 1'b1;
         end else if (!req_from_cpu || priv_ff) begin
            mem_wr = 1'b1;
         end else begin
            flags.denied = 1'b1;
         end
      end else if (word < 32'(PRIV_FLAT)) begin
         if (!req_cmd) begin
            rdsel  = RDSEL_MEM;
            mem_rd = 1'b1;
         end else begin
            mem_wr = 1'b1;
         end
      end
      // anything else is the unmapped hole: no effect, no flag
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept && mem_wr) begin
         valid_in[idx] = 1'b1;
      end
   end

   rfd_ram #(
      .WIDTH(64),
      .DEPTH(N_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (accept && mem_wr),
      .wr_addr (idx),
      .wr_data (req_wdata),
      .rd_en   (accept && mem_rd),
      .rd_addr (idx),
      .rd_data (ram_q)
   );

   assign s1_valid_in  = accept || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);

   always_comb begin
      case (s1_rdsel_ff)
         RDSEL_TIME: rsp_rdata_in = s1_time_ff;
         RDSEL_MEM:  rsp_rdata_in = s1_hit_ff ? ram_q : reset_word(s1_idx_ff);
         default:    rsp_rdata_in = 64'h0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         priv_ff      <= 1'b1;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         if (accept) begin
            priv_ff <= priv_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_flags_ff <= flags;
         s1_rdsel_ff <= rdsel;
         s1_time_ff  <= req_time_now;
         s1_hit_ff   <= valid_ff[idx];
         s1_idx_ff   <= idx;
      end
      if (s1_move) begin
         rsp_flags_ff <= s1_flags_ff;
         rsp_rdata_ff <= rsp_rdata_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rdata        = rsp_rdata_ff;
   assign rsp_irq_clear_wr = rsp_flags_ff.irq_clear;
   assign rsp_print_wr     = rsp_flags_ff.print;
   assign rsp_core_call_wr = rsp_flags_ff.core_call;
   assign rsp_priv_op_wr   = rsp_flags_ff.priv_op;
   assign rsp_ext_cmd_wr   = rsp_flags_ff.ext_cmd;
   assign rsp_command_wr   = rsp_flags_ff.command;
   assign rsp_ignored      = rsp_flags_ff.ignored;
   assign rsp_denied       = rsp_flags_ff.denied;

endmodule

// File: test/tcu_register_file_decode_check.sv
`timescale 1ns / 1ps

module tcu_register_file_decode_check import rfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_cmd,
   input  logic        req_from_cpu,
   input  logic [13:0] req_byte_addr,
   input  logic [63:0] req_wdata,
   input  logic [63:0] req_time_now,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [63:0] rsp_rdata,
   input  logic        rsp_irq_clear_wr,
   input  logic        rsp_print_wr,
   input  logic        rsp_core_call_wr,
   input  logic        rsp_priv_op_wr,
   input  logic        rsp_ext_cmd_wr,
   input  logic        rsp_command_wr,
   input  logic        rsp_ignored,
   input  logic        rsp_denied,
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      logic [63:0]   rdata;
      rsp_flags_type flags;
   } access_result_type;

   logic [63:0] unit_store     [N_UNIT];
   logic [63:0] command_store  [N_CMD];
   logic [63:0] endpoint_store [N_EPW];
   logic [63:0] buffer_store   [BUFFER_WORDS];
   logic [63:0] priv_store     [N_PRIV];

   access_result_type outstanding[$];
   int mismatches = 0;

   function automatic access_result_type decode_access(input logic is_write,
                                                       input logic from_core,
                                                       input logic [13:0] addr,
                                                       input logic [63:0] wdata,
                                                       input logic [63:0] now);
      access_result_type res;
      int a;
      int r;
      int w;
      int b;
      res = '0;
      a = int'(addr);
      if (a[2:0] != 3'd0 || a + 8 > SPACE_END) begin
         res.flags.ignored = 1'b1;
      end else if (a < 8 * N_UNIT) begin
         r = a >> 3;
         if (!is_write) begin
            res.rdata = (r == UNIT_CUR_TIME) ? now : unit_store[r];
         end else if (from_core) begin
            // core may only touch the two side-effect registers
            if (r == UNIT_IRQ_CLEAR) begin
               res.flags.irq_clear = 1'b1;
               unit_store[r] = wdata;
            end else if (r == UNIT_PRINT) begin
               res.flags.print = 1'b1;
               unit_store[r] = wdata;
            end
         end else begin
            unit_store[r] = wdata;
         end
      end else if (a >= PRIV_WORD * 8) begin
         r = (a >> 3) - PRIV_WORD;
         if (!is_write) begin
            res.rdata = priv_store[r];
         end else begin
            if (r == PRIV_CORE_CALL) begin
               res.flags.core_call = 1'b1;
            end else if (r == PRIV_PRIV_OP) begin
               res.flags.priv_op = 1'b1;
            end else if (r == PRIV_EXT_CMD && !from_core) begin
               res.flags.ext_cmd = 1'b1;
            end
            if (r != PRIV_EXT_CMD || !from_core) begin
               priv_store[r] = wdata;
            end
         end
      end else if (a < 8 * EP_WORD) begin
         r = (a >> 3) - N_UNIT;
         if (!is_write) begin
            res.rdata = command_store[r];
         end else if (from_core) begin
            if (r == CMD_COMMAND) begin
               res.flags.command = 1'b1;
            end
            command_store[r] = wdata;
         end
      end else begin
         w = (a >> 3) - EP_WORD;
         if (w < N_EPW) begin
            if (!is_write) begin
               res.rdata = endpoint_store[w];
            end else if (!from_core || (unit_store[UNIT_FEATURES] & FEAT_PRIV_BIT) != 0) begin
               endpoint_store[w] = wdata;
            end else begin
               res.flags.denied = 1'b1;
            end
         end else begin
            b = w - N_EPW;
            // past the last buffer word: unmapped hole, no effect
            if (b < BUFFER_WORDS) begin
               if (!is_write) begin
                  res.rdata = buffer_store[b];
               end else begin
                  buffer_store[b] = wdata;
               end
            end
         end
      end
      return res;
   endfunction

   task automatic compare_field(input string name, input logic [63:0] want_v,
                                input logic [63:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %h, got %h", name, want_v, got_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : monitor
      access_result_type want;
      if (reset) begin
         foreach (unit_store[i]) unit_store[i] = '0;
         foreach (command_store[i]) command_store[i] = '0;
         foreach (endpoint_store[i]) endpoint_store[i] = '0;
         foreach (buffer_store[i]) buffer_store[i] = '0;
         foreach (priv_store[i]) priv_store[i] = '0;
         unit_store[UNIT_FEATURES] = FEAT_PRIV_BIT;
         priv_store[PRIV_CUR_VPE]  = INVALID_VPE;
         outstanding.delete();
      end else begin
         // response can never be for an item accepted at this same edge
         if (rsp_valid && !rsp_stall) begin
            if (outstanding.size() == 0) begin
               $error("response item with no request outstanding");
               mismatches++;
            end else begin
               want = outstanding.pop_front();
               compare_field("rdata", want.rdata, rsp_rdata);
               compare_field("irq_clear_wr", 64'(want.flags.irq_clear),
                             64'(rsp_irq_clear_wr));
               compare_field("print_wr", 64'(want.flags.print), 64'(rsp_print_wr));
               compare_field("core_call_wr", 64'(want.flags.core_call),
                             64'(rsp_core_call_wr));
               compare_field("priv_op_wr", 64'(want.flags.priv_op),
                             64'(rsp_priv_op_wr));
               compare_field("ext_cmd_wr", 64'(want.flags.ext_cmd),
                             64'(rsp_ext_cmd_wr));
               compare_field("command_wr", 64'(want.flags.command),
                             64'(rsp_command_wr));
               compare_field("ignored", 64'(want.flags.ignored), 64'(rsp_ignored));
               compare_field("denied", 64'(want.flags.denied), 64'(rsp_denied));
            end
         end
         if (req_valid && !req_stall) begin
            outstanding.push_back(decode_access(req_cmd, req_from_cpu, req_byte_addr,
                                                req_wdata, req_time_now));
         end
      end
      pending_count <= outstanding.size();
      fail_count    <= mismatches;
   end

endmodule

// File: test/tcu_register_file_decode_test.sv
`timescale 1ns / 1ps

module tcu_register_file_decode_test;
   import rfd_pkg::*;

   localparam logic ACC_READ  = 1'b0;
   localparam logic ACC_WRITE = 1'b1;
   localparam logic SRC_NET   = 1'b0;
   localparam logic SRC_CORE  = 1'b1;

   localparam int CMD_BASE  = N_UNIT * 8;
   localparam int EP_BASE   = EP_WORD * 8;
   localparam int BUF_BASE  = BUF_WORD * 8;
   localparam int HOLE_BASE = PRIV_FLAT * 8;
   localparam int PRIV_BASE = PRIV_WORD * 8;

   localparam int RANDOM_ITEMS = 900;
   localparam int CYCLE_LIMIT  = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_cmd = 1'b0;
   logic        req_from_cpu = 1'b0;
   logic [13:0] req_byte_addr = '0;
   logic [63:0] req_wdata = '0;
   logic [63:0] req_time_now = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_rdata;
   logic        rsp_irq_clear_wr;
   logic        rsp_print_wr;
   logic        rsp_core_call_wr;
   logic        rsp_priv_op_wr;
   logic        rsp_ext_cmd_wr;
   logic        rsp_command_wr;
   logic        rsp_ignored;
   logic        rsp_denied;
   int          fail_count;
   int          pending_count;

   int burst_left = 0;
   int stall_mode = 0;
   int stall_phase_left = 0;
   int cycle_count = 0;

   tcu_register_file_decode DUT (.*);

   tcu_register_file_decode_check checker_inst (.*);

   always #5 clock = ~clock;

   // receiver stall pattern: phases of no stall, light stall and heavy stall
   always @(posedge clock) begin
      if (stall_phase_left == 0) begin
         stall_mode       = $urandom_range(0, 2);
         stall_phase_left = $urandom_range(10, 60);
      end else begin
         stall_phase_left--;
      end
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_stall <= ($urandom_range(0, 7) < 5);
         end
      endcase
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   task automatic send_item(input logic op, input logic src, input int addr,
                            input logic [63:0] data, input logic [63:0] now);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      req_valid     <= 1'b1;
      req_cmd       <= op;
      req_from_cpu  <= src;
      req_byte_addr <= 14'(addr);
      req_wdata     <= data;
      req_time_now  <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
   endtask

   initial begin
      int sel;
      int addr;
      logic [63:0] data;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: unit registers and source rules
      send_item(ACC_READ, SRC_CORE, UNIT_FEATURES * 8, '0, '0);
      send_item(ACC_READ, SRC_CORE, UNIT_CUR_TIME * 8, '0, '1);
      send_item(ACC_READ, SRC_NET, UNIT_CUR_TIME * 8, '1, '0);
      send_item(ACC_WRITE, SRC_CORE, UNIT_FEATURES * 8, '0, '0);
      send_item(ACC_WRITE, SRC_CORE, UNIT_CUR_TIME * 8, '1, '0);
      send_item(ACC_WRITE, SRC_CORE, UNIT_IRQ_CLEAR * 8, '1, '0);
      send_item(ACC_WRITE, SRC_CORE, UNIT_PRINT * 8, 64'h0123456789abcdef, '0);
      send_item(ACC_WRITE, SRC_NET, UNIT_IRQ_CLEAR * 8, 64'h5a5a, '0);
      send_item(ACC_WRITE, SRC_NET, UNIT_CUR_TIME * 8, '1, '0);
      send_item(ACC_READ, SRC_CORE, UNIT_CUR_TIME * 8, '0, 64'h8000000000000001);
      send_item(ACC_READ, SRC_CORE, PRIV_BASE + PRIV_CUR_VPE * 8, '0, '0);
      // command and privileged registers
      send_item(ACC_WRITE, SRC_NET, CMD_BASE + CMD_COMMAND * 8, '1, '0);
      send_item(ACC_WRITE, SRC_CORE, CMD_BASE + CMD_COMMAND * 8, 64'hdead, '0);
      send_item(ACC_READ, SRC_NET, CMD_BASE + CMD_COMMAND * 8, '0, '0);
      send_item(ACC_WRITE, SRC_CORE, PRIV_BASE + PRIV_CORE_CALL * 8, '1, '0);
      send_item(ACC_WRITE, SRC_NET, PRIV_BASE + PRIV_PRIV_OP * 8, 64'h77, '0);
      send_item(ACC_WRITE, SRC_CORE, PRIV_BASE + PRIV_EXT_CMD * 8, '1, '0);
      send_item(ACC_WRITE, SRC_NET, PRIV_BASE + PRIV_EXT_CMD * 8, 64'h99, '0);
      send_item(ACC_READ, SRC_CORE, PRIV_BASE + PRIV_EXT_CMD * 8, '0, '0);
      // endpoints with and without privilege
      send_item(ACC_WRITE, SRC_CORE, EP_BASE, '1, '0);
      send_item(ACC_WRITE, SRC_NET, UNIT_FEATURES * 8, '0, '0);
      send_item(ACC_WRITE, SRC_CORE, EP_BASE + (N_EPW - 1) * 8, '1, '0);
      send_item(ACC_WRITE, SRC_NET, EP_BASE + (N_EPW - 1) * 8, 64'hfeed, '0);
      send_item(ACC_READ, SRC_CORE, EP_BASE + (N_EPW - 1) * 8, '0, '0);
      // buffer, hole, misaligned and out of range
      send_item(ACC_WRITE, SRC_NET, BUF_BASE + (BUFFER_WORDS - 1) * 8, '1, '0);
      send_item(ACC_READ, SRC_CORE, BUF_BASE + (BUFFER_WORDS - 1) * 8, '0, '0);
      send_item(ACC_READ, SRC_CORE, HOLE_BASE, '0, '0);
      send_item(ACC_WRITE, SRC_NET, PRIV_BASE - 8, '1, '0);
      send_item(ACC_WRITE, SRC_CORE, BUF_BASE + 3, '1, '0);
      send_item(ACC_READ, SRC_NET, SPACE_END, '0, '1);
      send_item(ACC_READ, SRC_NET, 16383, '0, '1);
      send_item(ACC_WRITE, SRC_CORE, SPACE_END - 8, '1, '0);
      send_item(ACC_READ, SRC_CORE, SPACE_END - 8, '0, '0);
      send_item(ACC_WRITE, SRC_NET, UNIT_FEATURES * 8, FEAT_PRIV_BIT, '0);

      repeat (RANDOM_ITEMS) begin
         sel = $urandom_range(0, 99);
         if (sel < 15) begin
            addr = $urandom_range(0, N_UNIT - 1) * 8;
         end else if (sel < 27) begin
            addr = CMD_BASE + $urandom_range(0, N_CMD - 1) * 8;
         end else if (sel < 52) begin
            addr = EP_BASE + $urandom_range(0, N_EPW - 1) * 8;
         end else if (sel < 74) begin
            addr = BUF_BASE + $urandom_range(0, BUFFER_WORDS - 1) * 8;
         end else if (sel < 88) begin
            addr = PRIV_BASE + $urandom_range(0, N_PRIV - 1) * 8;
         end else if (sel < 92) begin
            addr = $urandom_range(PRIV_FLAT, PRIV_WORD - 1) * 8;
         end else if (sel < 96) begin
            addr = ($urandom_range(0, 2047) << 3) | $urandom_range(1, 7);
         end else begin
            addr = $urandom_range(SPACE_END - 7, 16383);
         end
         case ($urandom_range(0, 9))
            0: data = '1;
            1: data = '0;
            default: data = {$urandom, $urandom};
         endcase
         send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), addr, data,
                   {$urandom, $urandom});
      end
      req_valid <= 1'b0;

      // the count is registered, so it lags behind the last accepted item
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
